// ===== hdl/vcw_pkg.sv =====
// Package for the Vegas congestion window block: field widths, reset values,
// register map, constant-divide factors and the configuration structs.
// No dependencies; used by vcw_csr and vegas_congestion_window.
package vcw_pkg;

   // fixed field widths
   localparam int WIN_W      = 24;
   localparam int RTT_IN_W   = 24;
   localparam int BAND_W     = 16;
   localparam int EPOCH_US_W = 24;
   localparam int COUNT_W    = 24;
   localparam int ELAPSED_W  = 16;

   // default generics for the top level
   localparam int DEF_WINDOW_FRAC_BITS = 8;
   localparam int DEF_RTT_BITS         = 24;

   // bands are Q8.8 segments per second
   localparam int BAND_FRAC_BITS = 8;

   // microseconds per second, and the bits it needs
   localparam int USEC_PER_SEC = 1000000;
   localparam int MEGA_W       = 20;

   // x / 1000 = (x * magic) >> 38, exact for any 32 bit x
   localparam logic [63:0] DIV1000_MAGIC = 64'd274877907;
   localparam int          DIV1000_SHIFT = 38;
   // x / 5 = (x * magic) >> 34, exact for any 32 bit x
   localparam logic [63:0] DIV5_MAGIC = 64'hCCCC_CCCD;
   localparam int          DIV5_SHIFT = 34;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIN_W-1:0]      RST_INITIAL_WINDOW    = 24'd256;
   localparam logic [WIN_W-1:0]      RST_INITIAL_THRESHOLD = 24'hFF_FFFF;
   localparam logic [BAND_W-1:0]     RST_BAND_ALPHA        = 16'd512;
   localparam logic [BAND_W-1:0]     RST_BAND_BETA         = 16'd1024;
   localparam logic [BAND_W-1:0]     RST_BAND_GAMMA        = 16'd2048;
   localparam logic [EPOCH_US_W-1:0] RST_MIN_EPOCH_US      = 24'd100000;

   typedef enum logic [2:0] {
      REG_INITIAL_WINDOW    = 3'd0,
      REG_INITIAL_THRESHOLD = 3'd1,
      REG_BAND_ALPHA        = 3'd2,
      REG_BAND_BETA         = 3'd3,
      REG_BAND_GAMMA        = 3'd4,
      REG_MIN_EPOCH_US      = 3'd5
   } reg_idx_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic [WIN_W-1:0]      initial_window;
      logic [WIN_W-1:0]      initial_threshold;
      logic [BAND_W-1:0]     band_alpha;
      logic [BAND_W-1:0]     band_beta;
      logic [BAND_W-1:0]     band_gamma;
      logic [EPOCH_US_W-1:0] min_epoch_us;
   } cfg_type;

   // a write to an initial register also reloads the live value
   typedef struct packed {
      logic             window;
      logic             threshold;
      logic [WIN_W-1:0] value;
   } cfg_load_type;

endpackage

// ===== hdl/vcw_csr.sv =====
// Configuration register file for the Vegas congestion window block.
// APB-style write/read port; depends on vcw_pkg.
module vcw_csr import vcw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output cfg_load_type          load
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in         = cfg_ff;
      load.window    = 1'b0;
      load.threshold = 1'b0;
      load.value     = csr_pwdata[WIN_W-1:0];
      if (wr_en) begin
         unique case (idx)
            REG_INITIAL_WINDOW: begin
               cfg_in.initial_window = csr_pwdata[WIN_W-1:0];
               load.window           = 1'b1;
            end
            REG_INITIAL_THRESHOLD: begin
               cfg_in.initial_threshold = csr_pwdata[WIN_W-1:0];
               load.threshold           = 1'b1;
            end
            REG_BAND_ALPHA:   cfg_in.band_alpha   = csr_pwdata[BAND_W-1:0];
            REG_BAND_BETA:    cfg_in.band_beta    = csr_pwdata[BAND_W-1:0];
            REG_BAND_GAMMA:   cfg_in.band_gamma   = csr_pwdata[BAND_W-1:0];
            REG_MIN_EPOCH_US: cfg_in.min_epoch_us = csr_pwdata[EPOCH_US_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_INITIAL_WINDOW:    csr_prdata = CSR_DATA_W'(cfg_ff.initial_window);
         REG_INITIAL_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.initial_threshold);
         REG_BAND_ALPHA:        csr_prdata = CSR_DATA_W'(cfg_ff.band_alpha);
         REG_BAND_BETA:         csr_prdata = CSR_DATA_W'(cfg_ff.band_beta);
         REG_BAND_GAMMA:        csr_prdata = CSR_DATA_W'(cfg_ff.band_gamma);
         REG_MIN_EPOCH_US:      csr_prdata = CSR_DATA_W'(cfg_ff.min_epoch_us);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_window    <= RST_INITIAL_WINDOW;
         cfg_ff.initial_threshold <= RST_INITIAL_THRESHOLD;
         cfg_ff.band_alpha        <= RST_BAND_ALPHA;
         cfg_ff.band_beta         <= RST_BAND_BETA;
         cfg_ff.band_gamma        <= RST_BAND_GAMMA;
         cfg_ff.min_epoch_us      <= RST_MIN_EPOCH_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/vegas_congestion_window.sv =====
// Vegas congestion window engine, top level. Depends on vcw_pkg and vcw_csr.
// Requests pass the input register, then on firing load the result register.
// Throughput: one request per cycle unless rsp_tready stalls, except for a bubble
//   after each epoch opens (slow start exit or epoch close), while the band products,
//   the epoch tick target and epoch_window * 1e6 are registered for the next close.
// Reset: synchronous, active high; window and threshold take the initial
//   registers' reset values, slow start on, all epoch state cleared.
module vegas_congestion_window import vcw_pkg::*; #(
   parameter int WINDOW_FRAC_BITS = DEF_WINDOW_FRAC_BITS,
   parameter int RTT_BITS         = DEF_RTT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [23:0] rtt_us
   input  logic [1:0]            req_tuser,   // [0] operation, [1] sample_ok
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // [23:0] window_q8, [47:24] threshold_q8,
                                              // [71:48] base_rtt_out
   output logic [3:0]            rsp_tuser,   // [0] in_slow_start, [1] window_changed,
                                              // [2] left_slow_start, [3] epoch_ended
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int F = WINDOW_FRAC_BITS;

   localparam logic [WIN_W-1:0] WIN_MAX   = '1;
   localparam logic [WIN_W-1:0] ONE_SEG   = WIN_W'(64'd1 << F);
   localparam logic [WIN_W-1:0] TWO_SEG   = WIN_W'(64'd2 << F);
   localparam logic [WIN_W-1:0] THREE_SEG = WIN_W'(64'd3 << F);
   localparam logic [31:0]      RTT_MAX32 = 32'((64'd1 << RTT_BITS) - 64'd1);

   localparam int CNT_SEG_W = COUNT_W + F;
   localparam int E_W       = WIN_W + MEGA_W;
   localparam int CSC_W     = E_W + F;
   localparam int G_W       = BAND_W + RTT_BITS;
   localparam int CMP_W     = (CSC_W + BAND_FRAC_BITS > G_W + F) ?
                              CSC_W + BAND_FRAC_BITS : G_W + F;
   localparam int Q_W       = 64 - DIV1000_SHIFT;

   localparam logic [CSC_W-1:0] CSC_STEP = CSC_W'(64'(USEC_PER_SEC) << F);

   cfg_type      cfg;
   cfg_load_type load;

   vcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .load        (load)
   );

   // input register
   logic                in_valid_ff, in_valid_in;
   op_type              in_op_ff;
   logic [RTT_IN_W-1:0] in_rtt_ff;
   logic                in_ok_ff;

   // congestion state
   logic [WIN_W-1:0]     win_ff, win_in;
   logic [WIN_W-1:0]     thr_ff, thr_in;
   logic                 ss_ff, ss_in;
   logic [RTT_BITS-1:0]  base_ff, base_in;
   logic                 known_ff, known_in;
   logic [WIN_W-1:0]     ewin_ff, ewin_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CSC_W-1:0]     csc_ff, csc_in;   // count * 1e6 << F, tracked with count
   logic [RTT_BITS-1:0]  emin_ff, emin_in;
   logic [RTT_BITS-1:0]  elen_ff, elen_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 pend_ff, pend_in;

   // per-epoch products, registered from the state above
   logic [G_W-1:0]       ga_ff, gb_ff, gg_ff;
   logic [E_W-1:0]       e_ff;
   logic [ELAPSED_W-1:0] target_ff, target_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [WIN_W-1:0]     res_win_ff, res_thr_ff, res_base_ff;
   logic                 res_ss_ff, res_chg_ff, res_left_ff, res_end_ff;
   logic [31:0]          base32;

   logic fire, changed, left, ended, do_open;

   // helpers
   logic [31:0]           rtt32, mep32;
   logic [RTT_BITS-1:0]   rtt_sat, mep_rtt;
   logic [RTT_BITS-1:0]   ss_base;
   logic                  exit_hit;
   logic [63:0]           prod5, prod1000;
   logic [WIN_W-1:0]      t45, exit_win, grow_win, dec_win;
   logic [CNT_SEG_W-1:0]  cn;
   logic                  over;
   logic [CSC_W-1:0]      diff;
   logic [CMP_W-1:0]      lhs, ga_c, gb_c, gg_c;
   logic [ELAPSED_W-1:0]  elapsed_inc;
   logic                  close_hit;
   logic [Q_W-1:0]        q1000;

   assign fire       = in_valid_ff & ~pend_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | fire;

   assign in_valid_in  = (req_tvalid & req_tready) | (in_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & ~rsp_tready);

   always_comb begin
      rtt32   = 32'(in_rtt_ff);
      rtt_sat = (rtt32 > RTT_MAX32) ? RTT_MAX32[RTT_BITS-1:0] : rtt32[RTT_BITS-1:0];
      mep32   = 32'(cfg.min_epoch_us);
      mep_rtt = (mep32 > RTT_MAX32) ? RTT_MAX32[RTT_BITS-1:0] : mep32[RTT_BITS-1:0];
   end

   // slow start arithmetic
   assign ss_base  = (!known_ff || rtt_sat < base_ff) ? rtt_sat : base_ff;
   assign exit_hit = ((RTT_BITS+4)'(rtt_sat) * 4'd10) >= ((RTT_BITS+4)'(ss_base) * 4'd11);
   assign prod5    = 64'({win_ff, 2'b00}) * DIV5_MAGIC;
   assign t45      = prod5[DIV5_SHIFT +: WIN_W];
   assign exit_win = (t45 > TWO_SEG) ? t45 : TWO_SEG;
   assign grow_win = (win_ff > WIN_MAX - ONE_SEG) ? WIN_MAX : win_ff + ONE_SEG;
   assign dec_win  = (win_ff >= THREE_SEG) ? win_ff - ONE_SEG : TWO_SEG;

   // epoch close arithmetic: (ewin - cn) * 1e6 * 256 against band * (len << F)
   assign cn   = CNT_SEG_W'(count_ff) << F;
   assign over = cn > CNT_SEG_W'(ewin_ff);
   assign diff = CSC_W'(e_ff) - csc_ff;
   assign lhs  = CMP_W'(diff) << BAND_FRAC_BITS;
   assign ga_c = CMP_W'(ga_ff) << F;
   assign gb_c = CMP_W'(gb_ff) << F;
   assign gg_c = CMP_W'(gg_ff) << F;

   assign elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign close_hit   = elapsed_inc >= target_ff;

   always_comb begin
      win_in     = win_ff;
      thr_in     = thr_ff;
      ss_in      = ss_ff;
      base_in    = base_ff;
      known_in   = known_ff;
      ewin_in    = ewin_ff;
      count_in   = count_ff;
      csc_in     = csc_ff;
      emin_in    = emin_ff;
      elen_in    = elen_ff;
      elapsed_in = elapsed_ff;
      pend_in    = 1'b0;
      changed    = 1'b0;
      left       = 1'b0;
      ended      = 1'b0;
      do_open    = 1'b0;

      if (fire) begin
         if (in_op_ff == OP_TICK) begin
            if (!ss_ff) begin
               elapsed_in = elapsed_inc;
               if (close_hit) begin
                  changed = 1'b1;
                  ended   = 1'b1;
                  do_open = 1'b1;
                  if (over) begin
                     if (emin_ff < base_ff) begin
                        base_in = emin_ff;
                     end
                     win_in = grow_win;
                  end else if (lhs <= gg_c) begin
                     if (lhs < ga_c) begin
                        win_in = grow_win;
                     end else if (lhs > gb_c) begin
                        win_in = dec_win;
                     end
                  end else if (emin_ff > base_ff) begin
                     base_in = emin_ff;
                  end
               end
            end
         end else if (ss_ff) begin
            base_in  = ss_base;
            known_in = 1'b1;
            if (exit_hit) begin
               ss_in   = 1'b0;
               thr_in  = exit_win;
               win_in  = exit_win;
               changed = 1'b1;
               left    = 1'b1;
               do_open = 1'b1;
            end else if (win_ff < thr_ff) begin
               win_in  = grow_win;
               changed = 1'b1;
            end
         end else begin
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
               csc_in   = csc_ff + CSC_STEP;
            end
            // first arrival of an epoch always takes its sample
            if (emin_ff == '0) begin
               emin_in = rtt_sat;
            end else if (in_ok_ff && rtt_sat < emin_ff) begin
               emin_in = rtt_sat;
            end
         end

         if (do_open) begin
            elen_in    = (base_in > mep_rtt) ? base_in : mep_rtt;
            ewin_in    = win_in;
            count_in   = '0;
            csc_in     = '0;
            emin_in    = '0;
            elapsed_in = '0;
            pend_in    = 1'b1;
         end
      end

      if (load.window) begin
         win_in = load.value;
      end
      if (load.threshold) begin
         thr_in = load.value;
      end
   end

   assign base32 = 32'(base_in);

   // tick target = clamp(len / 1000, 1, 65535)
   assign prod1000 = 64'(32'(elen_ff)) * DIV1000_MAGIC;
   assign q1000    = prod1000[63:DIV1000_SHIFT];
   always_comb begin
      if (q1000 == '0) begin
         target_in = ELAPSED_W'(1);
      end else if (q1000 > Q_W'({ELAPSED_W{1'b1}})) begin
         target_in = '1;
      end else begin
         target_in = q1000[ELAPSED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ga_ff     <= G_W'(cfg.band_alpha) * G_W'(elen_ff);
      gb_ff     <= G_W'(cfg.band_beta) * G_W'(elen_ff);
      gg_ff     <= G_W'(cfg.band_gamma) * G_W'(elen_ff);
      e_ff      <= E_W'(ewin_ff) * E_W'(USEC_PER_SEC);
      target_ff <= target_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= op_type'(req_tuser[0]);
         in_ok_ff  <= req_tuser[1];
         in_rtt_ff <= req_tdata[RTT_IN_W-1:0];
      end
      if (fire) begin
         res_win_ff  <= win_in;
         res_thr_ff  <= thr_in;
         res_base_ff <= base32[WIN_W-1:0];
         res_ss_ff   <= ss_in;
         res_chg_ff  <= changed;
         res_left_ff <= left;
         res_end_ff  <= ended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         win_ff       <= RST_INITIAL_WINDOW;
         thr_ff       <= RST_INITIAL_THRESHOLD;
         ss_ff        <= 1'b1;
         base_ff      <= '0;
         known_ff     <= 1'b0;
         ewin_ff      <= '0;
         count_ff     <= '0;
         csc_ff       <= '0;
         emin_ff      <= '0;
         elen_ff      <= '0;
         elapsed_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         win_ff       <= win_in;
         thr_ff       <= thr_in;
         ss_ff        <= ss_in;
         base_ff      <= base_in;
         known_ff     <= known_in;
         ewin_ff      <= ewin_in;
         count_ff     <= count_in;
         csc_ff       <= csc_in;
         emin_ff      <= emin_in;
         elen_ff      <= elen_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_base_ff, res_thr_ff, res_win_ff};
   assign rsp_tuser  = {res_end_ff, res_left_ff, res_chg_ff, res_ss_ff};

   // products are stale only while pend_ff is set, and pend_ff never stays set
   a_pend_single: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("epoch open bubble lasted more than one cycle");

   // slow start is left once and never re-entered
   a_ss_sticky: assert property (@(posedge clock) disable iff (reset)
      !ss_ff |=> !ss_ff)
      else $error("slow start flag set again");

   // once the target is settled, the tick count stays below it between closes
   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      (!ss_ff && !pend_ff) |-> (elapsed_ff < target_ff))
      else $error("epoch tick count passed its target");

   // epoch end and slow start exit both announce the window, outside slow start
   a_flags: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (res_end_ff || res_left_ff)) |-> (res_chg_ff && !res_ss_ff))
      else $error("inconsistent result flags");

endmodule
